/* sv/alps_pkg.sv */
// alps_pkg: types and fixed constants of the addressable LED pulse serializer.
// No dependencies; imported by every module of the block.
package alps_pkg;

    localparam int BYTES_PER_PIXEL = 3;
    localparam int BYTE_W          = 8;
    localparam int PIXEL_BITS      = BYTES_PER_PIXEL * BYTE_W;
    localparam int SLOT_W          = 2;
    localparam int WIDTH_W         = 8;
    localparam int COUNT_W         = 12;
    localparam int ORDER_W         = 6;
    localparam int CFG_INDEX_W     = 4;
    localparam int CFG_DATA_W      = 12;
    localparam int BIT_CNT_W       = $clog2(PIXEL_BITS + 1);

    localparam logic [WIDTH_W-1:0] ONE_WIDTH_RST     = 8'd15;
    localparam logic [WIDTH_W-1:0] ZERO_WIDTH_RST    = 8'd5;
    localparam logic [ORDER_W-1:0] COLOR_ORDER_RST   = 6'd18;
    localparam logic [COUNT_W-1:0] RESET_PERIODS_RST = 12'd48;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ONE_WIDTH     = 4'd0,
        CFG_ZERO_WIDTH    = 4'd1,
        CFG_COLOR_ORDER   = 4'd2,
        CFG_RESET_PERIODS = 4'd3
    } alps_cfg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              last_pixel;
    } alps_in_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] pulse_width;
        logic [COUNT_W-1:0] repeat_count;
        logic               last;
    } alps_out_t;

    // Pixel in wire order, ready for the back end.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] bits;
        logic                  last_pixel;
    } alps_item_t;

    // Timing registers seen by the back end.
    typedef struct packed {
        logic [WIDTH_W-1:0] one_width;
        logic [WIDTH_W-1:0] zero_width;
        logic [COUNT_W-1:0] reset_periods;
    } alps_timing_t;

    typedef struct packed {
        logic                 busy;
        logic                 final_adv;
        logic [BIT_CNT_W-1:0] bit_cnt;
    } alps_back_st_t;

endpackage

/* sv/alps_front.sv */
// alps_front: accepts pixels and reorders the color bytes into wire slots.
// Depends on alps_pkg.
module alps_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  alps_pkg::alps_in_t                  s_data,
    input  logic [alps_pkg::ORDER_W-1:0]        color_order,
    output logic                                item_valid,
    input  logic                                item_ready,
    output alps_pkg::alps_item_t                item
);
    import alps_pkg::*;

    logic       valid_reg, valid_next;
    alps_item_t item_reg, item_next;
    logic [BYTE_W-1:0] slots [BYTES_PER_PIXEL];

    // Later color wins on a slot collision; out-of-range slot drops the color.
    always_comb begin
        for (int s = 0; s < BYTES_PER_PIXEL; s++) begin
            slots[s] = '0;
        end
        for (int s = 0; s < BYTES_PER_PIXEL; s++) begin
            if (color_order[5:4] == SLOT_W'(s)) slots[s] = s_data.red;
            if (color_order[3:2] == SLOT_W'(s)) slots[s] = s_data.green;
            if (color_order[1:0] == SLOT_W'(s)) slots[s] = s_data.blue;
        end
    end

    assign s_ready = !valid_reg || item_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
            for (int s = 0; s < BYTES_PER_PIXEL; s++) begin
                item_next.bits[PIXEL_BITS-1-s*BYTE_W -: BYTE_W] = slots[s];
            end
            item_next.last_pixel = s_data.last_pixel;
        end else if (item_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* sv/alps_queue.sv */
// alps_queue: short FIFO of reordered pixels between front and back end.
// Depends on alps_pkg.
module alps_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  alps_pkg::alps_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output alps_pkg::alps_item_t pop_item
);
    import alps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    alps_item_t        mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* sv/alps_back.sv */
// alps_back: 24 pulse-width results per pixel, plus a reset run after last_pixel.
// Depends on alps_pkg.
module alps_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  alps_pkg::alps_item_t  item,
    input  alps_pkg::alps_timing_t timing,
    output logic                  m_valid,
    input  logic                  m_ready,
    output alps_pkg::alps_out_t   m_data,
    output alps_pkg::alps_back_st_t status
);
    import alps_pkg::*;

    logic                  busy_reg, busy_next;
    logic [PIXEL_BITS-1:0] shift_reg, shift_next;
    logic                  lastpix_reg, lastpix_next;
    logic [BIT_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  mvalid_reg, mvalid_next;
    alps_out_t             mdata_reg, mdata_next;
    alps_out_t             result;
    logic                  adv, fin, take, in_reset;

    assign in_reset = (cnt_reg == BIT_CNT_W'(PIXEL_BITS));
    assign adv      = busy_reg && (!mvalid_reg || m_ready);
    assign fin      = in_reset || ((cnt_reg == BIT_CNT_W'(PIXEL_BITS - 1)) && !lastpix_reg);
    assign take     = item_valid && (!busy_reg || (adv && fin));
    assign item_ready = !busy_reg || (adv && fin);

    always_comb begin
        if (in_reset) begin
            result.pulse_width  = '0;
            result.repeat_count = timing.reset_periods;
            result.last         = 1'b1;
        end else begin
            result.pulse_width  = shift_reg[PIXEL_BITS-1] ? timing.one_width
                                                          : timing.zero_width;
            result.repeat_count = COUNT_W'(1);
            result.last         = fin;
        end
    end

    always_comb begin
        busy_next    = busy_reg;
        shift_next   = shift_reg;
        lastpix_next = lastpix_reg;
        cnt_next     = cnt_reg;
        mvalid_next  = mvalid_reg;
        mdata_next   = mdata_reg;
        if (take) begin
            busy_next    = 1'b1;
            shift_next   = item.bits;
            lastpix_next = item.last_pixel;
            cnt_next     = '0;
        end else if (adv && fin) begin
            busy_next = 1'b0;
        end else if (adv) begin
            shift_next = {shift_reg[PIXEL_BITS-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
        end
        if (adv) begin
            mvalid_next = 1'b1;
            mdata_next  = result;
        end else if (m_ready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
        shift_reg   <= shift_next;
        lastpix_reg <= lastpix_next;
        mdata_reg   <= mdata_next;
    end

    assign m_valid          = mvalid_reg;
    assign m_data           = mdata_reg;
    assign status.busy      = busy_reg;
    assign status.final_adv = adv && fin;
    assign status.bit_cnt   = cnt_reg;

endmodule

/* sv/addressable_led_pulse_serializer_unit.sv */
// addressable_led_pulse_serializer_unit: top level of the LED strip bit encoder.
// Depends on alps_pkg, alps_front, alps_queue and alps_back.
//
// Takes one pixel per transfer (red, green, blue, last_pixel), reorders the color
// bytes into wire slots with color_order (red slot in bits 5:4, green 3:2, blue
// 1:0; blue beats green beats red on a collision, an unnamed slot sends zero, a
// slot code of 3 drops that color) and emits one result per data bit, MSB of
// slot 0 first: pulse_width is one_width for a set bit and zero_width for a
// clear bit, repeat_count is 1. After a pixel flagged last_pixel a 25th result
// follows with pulse_width 0 and repeat_count = reset_periods (sent even when
// that is 0). The last flag marks the final result of each pixel. The back end
// sends one result per cycle while m_ready is high and pixels are waiting, so
// a pixel gives 24 results, or 25 with the reset run; that shifter sets the
// sustained rate. Input transfers are taken while earlier pixels shift: a front
// register and a QUEUE_DEPTH entry FIFO buffer pixels ahead of the shifter and
// its output register. Write configuration only while the block is idle.
module addressable_led_pulse_serializer_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  alps_pkg::alps_in_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output alps_pkg::alps_out_t                m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [alps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [alps_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import alps_pkg::*;

    // configuration registers
    logic [WIDTH_W-1:0] one_width_reg, one_width_next;
    logic [WIDTH_W-1:0] zero_width_reg, zero_width_next;
    logic [ORDER_W-1:0] color_order_reg, color_order_next;
    logic [COUNT_W-1:0] reset_periods_reg, reset_periods_next;

    alps_timing_t  timing;
    alps_item_t    front_item, q_item;
    logic          front_valid, q_ready, q_valid, q_pop;
    alps_back_st_t back_st;

    assign cfg_ready = 1'b1;

    // writes beyond the register list are dropped
    always_comb begin
        one_width_next     = one_width_reg;
        zero_width_next    = zero_width_reg;
        color_order_next   = color_order_reg;
        reset_periods_next = reset_periods_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (alps_cfg_idx_t'(cfg_index))
                CFG_ONE_WIDTH:     one_width_next     = cfg_data[WIDTH_W-1:0];
                CFG_ZERO_WIDTH:    zero_width_next    = cfg_data[WIDTH_W-1:0];
                CFG_COLOR_ORDER:   color_order_next   = cfg_data[ORDER_W-1:0];
                CFG_RESET_PERIODS: reset_periods_next = cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            one_width_reg     <= ONE_WIDTH_RST;
            zero_width_reg    <= ZERO_WIDTH_RST;
            color_order_reg   <= COLOR_ORDER_RST;
            reset_periods_reg <= RESET_PERIODS_RST;
        end else begin
            one_width_reg     <= one_width_next;
            zero_width_reg    <= zero_width_next;
            color_order_reg   <= color_order_next;
            reset_periods_reg <= reset_periods_next;
        end
    end

    assign timing.one_width     = one_width_reg;
    assign timing.zero_width    = zero_width_reg;
    assign timing.reset_periods = reset_periods_reg;

    // front end: accept and reorder
    alps_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .color_order (color_order_reg),
        .item_valid  (front_valid),
        .item_ready  (q_ready),
        .item        (front_item)
    );

    // decoupling queue
    alps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (q_ready),
        .push_item  (front_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_item   (q_item)
    );

    // back end: bit shifter with output register
    alps_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (q_valid),
        .item_ready (q_pop),
        .item       (q_item),
        .timing     (timing),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .status     (back_st)
    );

`ifndef SYNTHESIS
    // a queued pixel is not lost unless the back end takes it
    a_queue_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && !q_pop) |=> q_valid)
        else $error("queue lost an entry");

    // a stalled front register keeps its pixel
    a_front_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (front_valid && !q_ready) |=> (front_valid && $stable(front_item)))
        else $error("front register changed while stalled");

    // after the final result of a pixel the shifter is idle or restarted
    a_back_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        back_st.final_adv |=> (!back_st.busy || (back_st.bit_cnt == '0)))
        else $error("shifter did not restart after final result");

    // the shifter never runs past the reset result
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        back_st.busy |-> (back_st.bit_cnt <= BIT_CNT_W'(PIXEL_BITS)))
        else $error("bit counter out of range");
`endif

endmodule

/* sim/tb_addressable_led_pulse_serializer_unit.sv */
`timescale 1ns / 100ps
// tb_addressable_led_pulse_serializer_unit: self-checking bench for the LED pulse serializer.
// Depends on alps_pkg and addressable_led_pulse_serializer_unit; predicts every pulse
// transfer from its own copy of the registers and checks the result stream in order.
module tb_addressable_led_pulse_serializer_unit;
    import alps_pkg::*;

    localparam int  CYCLE_LIMIT   = 600000;
    localparam int  SETTLE_CYCLES = 8;    // settle time after the last predicted pulse, with margin
    localparam int  TAIL_CYCLES   = 30;
    localparam int  PHASE_ITEMS   = 45;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_IDX = 4'hF;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    alps_in_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    alps_out_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Register shadow used by the pulse predictor; follows every config transfer.
    logic [WIDTH_W-1:0]     cur_one_width     = ONE_WIDTH_RST;
    logic [WIDTH_W-1:0]     cur_zero_width    = ZERO_WIDTH_RST;
    logic [ORDER_W-1:0]     cur_color_order   = COLOR_ORDER_RST;
    logic [COUNT_W-1:0]     cur_reset_periods = RESET_PERIODS_RST;

    alps_out_t              expected_pulses[$];
    int                     err_count   = 0;
    int                     cycle_cnt   = 0;
    int                     tx_idle_pct = 0;   // chance per cycle the pixel source holds off
    int                     rx_stall_pct = 0;  // chance per cycle the pulse sink stalls

    addressable_led_pulse_serializer_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("addressable_led_pulse_serializer_unit verification failed");
            $finish;
        end
    end

    // Pulse sink back-pressure; redrawn every cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Wire-order encoding of one pixel: slot bytes placed red, green, blue so a
    // later color wins a shared slot; slot code 3 names nothing and drops the color.
    function automatic void encode_pixel(input alps_in_t px);
        logic [BYTE_W-1:0]  wire_byte [BYTES_PER_PIXEL];
        logic [SLOT_W-1:0]  slot_code;
        alps_out_t          pulse;
        for (int s = 0; s < BYTES_PER_PIXEL; s++)
            wire_byte[s] = '0;
        slot_code = cur_color_order[5:4];
        if (slot_code < BYTES_PER_PIXEL) wire_byte[slot_code] = px.red;
        slot_code = cur_color_order[3:2];
        if (slot_code < BYTES_PER_PIXEL) wire_byte[slot_code] = px.green;
        slot_code = cur_color_order[1:0];
        if (slot_code < BYTES_PER_PIXEL) wire_byte[slot_code] = px.blue;

        // 24 bit periods, slot 0 first, MSB first
        for (int s = 0; s < BYTES_PER_PIXEL; s++) begin
            for (int b = BYTE_W - 1; b >= 0; b--) begin
                pulse.pulse_width  = wire_byte[s][b] ? cur_one_width : cur_zero_width;
                pulse.repeat_count = COUNT_W'(1);
                pulse.last         = (s == BYTES_PER_PIXEL - 1) && (b == 0) && !px.last_pixel;
                expected_pulses.push_back(pulse);
            end
        end
        // trailing line-low reset run, sent even with a zero length
        if (px.last_pixel) begin
            pulse.pulse_width  = '0;
            pulse.repeat_count = cur_reset_periods;
            pulse.last         = 1'b1;
            expected_pulses.push_back(pulse);
        end
    endfunction

    // Result checker: each pulse transfer against the oldest prediction.
    always @(posedge aclk) begin
        alps_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pulses.size() == 0) begin
                $error("unexpected pulse transfer: pulse_width %0d repeat_count %0d last %0b",
                       m_data.pulse_width, m_data.repeat_count, m_data.last);
                err_count++;
            end else begin
                want = expected_pulses.pop_front();
                if (m_data.pulse_width !== want.pulse_width) begin
                    $error("pulse_width: expected %0d, got %0d",
                           want.pulse_width, m_data.pulse_width);
                    err_count++;
                end
                if (m_data.repeat_count !== want.repeat_count) begin
                    $error("repeat_count: expected %0d, got %0d",
                           want.repeat_count, m_data.repeat_count);
                    err_count++;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_data.last);
                    err_count++;
                end
            end
        end
    end

    // One pixel transfer, with an optional random hold-off first. Valid is left
    // high after the transfer so back-to-back pixels never drop it.
    task automatic send_pixel(input alps_in_t px);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        encode_pixel(px);
    endtask

    // Stop the pixel source, wait for every predicted pulse, then let the
    // pipeline settle so a register write lands on an idle block.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_pulses.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ONE_WIDTH:     cur_one_width     = val[WIDTH_W-1:0];
            CFG_ZERO_WIDTH:    cur_zero_width    = val[WIDTH_W-1:0];
            CFG_COLOR_ORDER:   cur_color_order   = val[ORDER_W-1:0];
            CFG_RESET_PERIODS: cur_reset_periods = val[COUNT_W-1:0];
            default: ;  // unmapped index: no register changes
        endcase
        @(posedge aclk);
    endtask

    // Reset register values, byte extremes, last_pixel both ways.
    task automatic test_default_timing();
        send_pixel('{red: 8'hFF, green: 8'h00, blue: 8'h00, last_pixel: 1'b0});
        send_pixel('{red: 8'h00, green: 8'hFF, blue: 8'h00, last_pixel: 1'b0});
        send_pixel('{red: 8'h00, green: 8'h00, blue: 8'hFF, last_pixel: 1'b1});
        send_pixel('{red: 8'hA5, green: 8'h5A, blue: 8'h3C, last_pixel: 1'b1});
        send_pixel('{red: 8'hFF, green: 8'hFF, blue: 8'hFF, last_pixel: 1'b0});
        send_pixel('{red: 8'h00, green: 8'h00, blue: 8'h00, last_pixel: 1'b1});
    endtask

    // Slot mapping: all colors colliding on slot 0, every color dropped,
    // plain permutations, an unused slot, and a dropped color beside a collision.
    task automatic test_color_order();
        logic [ORDER_W-1:0] orders [6] = '{6'b00_00_00, 6'b11_11_11, 6'b00_01_10,
                                           6'b10_01_00, 6'b11_00_01, 6'b01_01_11};
        foreach (orders[i]) begin
            wait_idle();
            write_reg(CFG_COLOR_ORDER, {6'h2A, orders[i]});
            send_pixel('{red: 8'hC3, green: 8'h81, blue: 8'h7E, last_pixel: i[0]});
        end
    endtask

    // Width and reset-length extremes, including a zero-length reset run,
    // stray upper data bits on narrow registers and a write to an unmapped index.
    task automatic test_timing_extremes();
        wait_idle();
        write_reg(CFG_ONE_WIDTH,     12'hF00);
        write_reg(CFG_ZERO_WIDTH,    12'h0FF);
        write_reg(CFG_RESET_PERIODS, 12'h000);
        write_reg(CFG_COLOR_ORDER,   {6'h00, COLOR_ORDER_RST});
        send_pixel('{red: 8'h5A, green: 8'hA5, blue: 8'hFF, last_pixel: 1'b1});
        send_pixel('{red: 8'h00, green: 8'hFF, blue: 8'h00, last_pixel: 1'b0});
        send_pixel('{red: 8'hFF, green: 8'h00, blue: 8'hFF, last_pixel: 1'b1});
        wait_idle();
        write_reg(CFG_ONE_WIDTH,     12'hFFF);
        write_reg(CFG_ZERO_WIDTH,    12'hA00);
        write_reg(CFG_RESET_PERIODS, 12'hFFF);
        write_reg(CFG_UNUSED_IDX,    12'h555);
        send_pixel('{red: 8'hFF, green: 8'h00, blue: 8'hAA, last_pixel: 1'b1});
        send_pixel('{red: 8'h55, green: 8'hFF, blue: 8'h00, last_pixel: 1'b1});
    endtask

    function automatic logic [WIDTH_W-1:0] pick_width();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return WIDTH_W'($urandom_range(255));
        endcase
    endfunction

    // Random strips under four source-idle and sink-stall phases; each phase starts from a fresh
    // random register set. Mostly well-formed strips (last_pixel only on the
    // final pixel), with some stray last flags mixed in.
    task automatic test_random_strips();
        int sent;
        int run_pixels;
        int stall_pct [4] = '{0, 0, 68, 23};
        int idle_pct  [4] = '{0, 68, 0, 23};
        alps_in_t px;
        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            tx_idle_pct  = idle_pct[phase];
            rx_stall_pct = stall_pct[phase];
            write_reg(CFG_ONE_WIDTH,  {4'($urandom_range(15)), pick_width()});
            write_reg(CFG_ZERO_WIDTH, {4'($urandom_range(15)), pick_width()});
            write_reg(CFG_COLOR_ORDER, CFG_DATA_W'($urandom_range(4095)));
            case ($urandom_range(3))
                0:       write_reg(CFG_RESET_PERIODS, 12'h000);
                1:       write_reg(CFG_RESET_PERIODS, 12'hFFF);
                default: write_reg(CFG_RESET_PERIODS, CFG_DATA_W'($urandom_range(4095)));
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                run_pixels = $urandom_range(1, 8);
                for (int i = 0; i < run_pixels; i++) begin
                    px.red        = BYTE_W'($urandom_range(255));
                    px.green      = BYTE_W'($urandom_range(255));
                    px.blue       = BYTE_W'($urandom_range(255));
                    px.last_pixel = (i == run_pixels - 1);
                    if ($urandom_range(4) == 0)
                        px.last_pixel = 1'($urandom_range(1));
                    send_pixel(px);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_timing();
        test_color_order();
        test_timing_extremes();
        test_random_strips();

        // drain, then give the pipeline time to show any stray transfer
        tx_idle_pct = 0;
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("addressable_led_pulse_serializer_unit verification clean");
        end else begin
            $display("addressable_led_pulse_serializer_unit verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/alps_pkg.sv
sv/alps_front.sv
sv/alps_queue.sv
sv/alps_back.sv
sv/addressable_led_pulse_serializer_unit.sv
sim/tb_addressable_led_pulse_serializer_unit.sv
